// ----- hdl/dss_pkg.sv -----
// Shared types, constants and helpers for the drum step sequencer.
// No dependencies; used by every module under hdl/.
`timescale 1ns / 1ps
`default_nettype none

package dss_pkg;

  localparam int STEPS         = 16;
  localparam int PATTERN_SLOTS = 32;
  localparam int BANK_SLOTS    = 16;
  localparam int NUM_INSTR     = 8;
  localparam int WORD_W        = NUM_INSTR + 1;
  localparam int STORE_DEPTH   = BANK_SLOTS * PATTERN_SLOTS * STEPS;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int TIME_W        = 32;
  localparam int FIELD_W       = 7;
  localparam int TABLE_W       = NUM_INSTR * FIELD_W;
  localparam int KIDX_W        = $clog2(NUM_INSTR);

  localparam logic [TIME_W-1:0] OFF_DELAY  = TIME_W'(110);
  localparam logic [TIME_W-1:0] STEP_TICKS = TIME_W'(120);
  localparam logic [TIME_W-1:0] BAR_TICKS  = TIME_W'(1920);

  // input modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_PLAY  = 2'd1;
  localparam logic [1:0] MODE_REST  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_SWING   = 3'd0;
  localparam logic [2:0] CFG_CHANNEL = 3'd1;
  localparam logic [2:0] CFG_NOTES   = 3'd2;
  localparam logic [2:0] CFG_VEL_NRM = 3'd3;
  localparam logic [2:0] CFG_VEL_ACC = 3'd4;

  localparam logic [5:0]         SWING_RST   = 6'd0;
  localparam logic [4:0]         CHANNEL_RST = 5'd10;
  localparam logic [TABLE_W-1:0] NOTES_RST   = TABLE_W'(56'd26082181674357540);
  localparam logic [TABLE_W-1:0] VEL_NRM_RST = TABLE_W'(56'd34042957813194300);
  localparam logic [TABLE_W-1:0] VEL_ACC_RST = TABLE_W'(56'd68085915626388600);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EMIT_ON,
    ST_EMIT_OFF,
    ST_ADVANCE
  } state_t;

  // operand select of the shared time adder
  typedef enum logic [2:0] {
    TOP_NONE,
    TOP_ON_EVEN,
    TOP_ON_ODD,
    TOP_OFF,
    TOP_STEP,
    TOP_BAR
  } time_op_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
  } store_req_t;

  function automatic logic [FIELD_W-1:0] field7(input logic [TABLE_W-1:0] tab,
                                                input logic [KIDX_W-1:0] k);
    return tab[k*FIELD_W +: FIELD_W];
  endfunction

  function automatic logic in_range(input logic [3:0] bank, input logic [4:0] pat);
    return (32'(bank) < BANK_SLOTS) && (32'(pat) < PATTERN_SLOTS);
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [3:0] bank,
                                                   input logic [4:0] pat,
                                                   input logic [3:0] step);
    return ADDR_W'((32'(bank) * PATTERN_SLOTS + 32'(pat)) * STEPS + 32'(step));
  endfunction

endpackage

`default_nettype wire

// ----- hdl/dss_store.sv -----
// Pattern store: one 9-bit step word per bank/pattern/step, single port
// write, registered read, with a clearing sweep after reset. Uses dss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dss_store (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire dss_pkg::store_req_t       req,
  output logic [dss_pkg::WORD_W-1:0]     rd_data,
  output logic                           clearing
);

  logic [dss_pkg::WORD_W-1:0] mem [dss_pkg::STORE_DEPTH];
  logic [dss_pkg::WORD_W-1:0] rd_data_r;
  logic [dss_pkg::ADDR_W-1:0] clr_addr_r;
  logic                       clearing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clearing_r <= 1'b1;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + dss_pkg::ADDR_W'(1);
      if (clr_addr_r == dss_pkg::ADDR_W'(dss_pkg::STORE_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clearing_r;

endmodule

`default_nettype wire

// ----- hdl/dss_time_unit.sv -----
// Time counter and the one 32-bit adder shared by event times and the
// step/bar advance. Uses dss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dss_time_unit (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire dss_pkg::time_op_t        op,
  input  wire logic [5:0]               swing,
  output logic [dss_pkg::TIME_W-1:0]    sum
);

  logic [dss_pkg::TIME_W-1:0] time_r;
  logic [dss_pkg::TIME_W-1:0] time_nxt;
  logic [dss_pkg::TIME_W-1:0] operand;

  always_comb begin
    unique case (op)
      dss_pkg::TOP_ON_ODD: operand = dss_pkg::TIME_W'(swing);
      dss_pkg::TOP_OFF:    operand = dss_pkg::OFF_DELAY;
      dss_pkg::TOP_STEP:   operand = dss_pkg::STEP_TICKS;
      dss_pkg::TOP_BAR:    operand = dss_pkg::BAR_TICKS;
      default:             operand = '0;
    endcase
    sum      = time_r + operand;
    time_nxt = ((op == dss_pkg::TOP_STEP) || (op == dss_pkg::TOP_BAR)) ? sum : time_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
    end else begin
      time_r <= time_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/drum_step_sequencer.sv -----
// Top level of the drum step sequencer: command sequencer, configuration
// registers and result registers. Uses dss_pkg, dss_store, dss_time_unit.
//
// A command is taken when start is high and busy is low. After reset the
// pattern store is swept clear, one word a cycle, and busy stays high until
// the sweep ends. A write item reads the step word, then writes back the
// merged word; a rest item goes straight to the time advance; a play item
// does one store read, a scan of eight note-on and eight note-off slots
// (one per instrument), then an advance in which the shared time adder
// advances the counter. A play of an empty or out-of-range step skips the
// scan. Each event appears on the out_ ports for one cycle with out_strobe
// high, the cycle after its scan slot; there is no backpressure, so the
// receiver must take every beat as it comes.
`timescale 1ns / 1ps
`default_nettype none

module drum_step_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_mode,
  input  wire logic [3:0]  in_step_index,
  input  wire logic [3:0]  in_instrument_index,
  input  wire logic [4:0]  in_pattern_index,
  input  wire logic [3:0]  in_bank_index,
  output logic             out_strobe,
  output logic             out_note_on,
  output logic [31:0]      out_event_time,
  output logic [4:0]       out_channel_out,
  output logic [6:0]       out_note_number,
  output logic [6:0]       out_velocity_out,
  output logic             out_last_event,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [55:0] cfg_data
);

  localparam int NI = dss_pkg::NUM_INSTR;

  dss_pkg::state_t state_r, state_nxt;

  logic [5:0]                   swing_r;
  logic [4:0]                   channel_r;
  logic [dss_pkg::TABLE_W-1:0]  notes_r, vel_nrm_r, vel_acc_r;

  logic [dss_pkg::ADDR_W-1:0]   addr_r, addr_nxt;
  logic [3:0]                   instr_r, instr_nxt;
  logic                         is_write_r, is_write_nxt;
  logic                         valid_r, valid_nxt;
  logic                         odd_r, odd_nxt;
  logic                         bar_r, bar_nxt;
  logic [dss_pkg::WORD_W-1:0]   word_r, word_nxt;
  logic [dss_pkg::KIDX_W-1:0]   k_r, k_nxt;

  logic                         strobe_r, strobe_nxt;
  logic                         note_on_r, note_on_nxt;
  logic [31:0]                  time_out_r, time_out_nxt;
  logic [6:0]                   note_r, note_nxt;
  logic [6:0]                   vel_r, vel_nxt;
  logic                         last_r, last_nxt;

  dss_pkg::store_req_t          store_req;
  logic [dss_pkg::WORD_W-1:0]   rd_data;
  logic                         clearing;
  dss_pkg::time_op_t            time_op;
  logic [dss_pkg::TIME_W-1:0]   time_sum;

  logic                         accept;
  logic [NI-1:0]                hits;
  logic                         hit;

  dss_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (store_req),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  dss_time_unit u_time (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (time_op),
    .swing (swing_r),
    .sum   (time_sum)
  );

  assign busy   = (state_r != dss_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign hits   = word_r[dss_pkg::WORD_W-1:1];
  assign hit    = hits[k_r];

  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    instr_nxt    = instr_r;
    is_write_nxt = is_write_r;
    valid_nxt    = valid_r;
    odd_nxt      = odd_r;
    bar_nxt      = bar_r;
    word_nxt     = word_r;
    k_nxt        = k_r;
    strobe_nxt   = 1'b0;
    note_on_nxt  = note_on_r;
    time_out_nxt = time_out_r;
    note_nxt     = note_r;
    vel_nxt      = vel_r;
    last_nxt     = 1'b0;
    time_op      = dss_pkg::TOP_NONE;
    store_req.rd_en   = 1'b0;
    store_req.rd_addr = dss_pkg::store_addr(in_bank_index, in_pattern_index, in_step_index);
    store_req.wr_en   = 1'b0;
    store_req.wr_addr = addr_r;
    store_req.wr_data = rd_data | (dss_pkg::WORD_W'(1) << instr_r);

    unique case (state_r)
      dss_pkg::ST_CLEAR: begin
        if (!clearing) state_nxt = dss_pkg::ST_IDLE;
      end
      dss_pkg::ST_IDLE: begin
        addr_nxt  = store_req.rd_addr;
        instr_nxt = in_instrument_index;
        valid_nxt = dss_pkg::in_range(in_bank_index, in_pattern_index);
        odd_nxt   = in_step_index[0];
        k_nxt     = '0;
        if (accept) begin
          case (in_mode)
            dss_pkg::MODE_WRITE: begin
              if (32'(in_instrument_index) <= NI && valid_nxt) begin
                store_req.rd_en = 1'b1;
                is_write_nxt    = 1'b1;
                state_nxt       = dss_pkg::ST_READ;
              end
            end
            dss_pkg::MODE_PLAY: begin
              store_req.rd_en = 1'b1;
              is_write_nxt    = 1'b0;
              bar_nxt         = 1'b0;
              state_nxt       = dss_pkg::ST_READ;
            end
            dss_pkg::MODE_REST: begin
              bar_nxt   = 1'b1;
              state_nxt = dss_pkg::ST_ADVANCE;
            end
            default: ;
          endcase
        end
      end
      dss_pkg::ST_READ: begin
        if (is_write_r) begin
          store_req.wr_en = 1'b1;
          state_nxt       = dss_pkg::ST_IDLE;
        end else begin
          word_nxt = valid_r ? rd_data : '0;
          // empty or out-of-range step: straight to the time advance
          if (!valid_r || rd_data[dss_pkg::WORD_W-1:1] == '0) begin
            state_nxt = dss_pkg::ST_ADVANCE;
          end else begin
            state_nxt = dss_pkg::ST_EMIT_ON;
          end
        end
      end
      dss_pkg::ST_EMIT_ON: begin
        time_op      = odd_r ? dss_pkg::TOP_ON_ODD : dss_pkg::TOP_ON_EVEN;
        strobe_nxt   = hit;
        note_on_nxt  = 1'b1;
        time_out_nxt = time_sum;
        note_nxt     = dss_pkg::field7(notes_r, k_r);
        vel_nxt      = dss_pkg::field7(word_r[0] ? vel_acc_r : vel_nrm_r, k_r);
        k_nxt        = k_r + dss_pkg::KIDX_W'(1);
        if (k_r == dss_pkg::KIDX_W'(NI - 1)) state_nxt = dss_pkg::ST_EMIT_OFF;
      end
      dss_pkg::ST_EMIT_OFF: begin
        time_op      = dss_pkg::TOP_OFF;
        strobe_nxt   = hit;
        note_on_nxt  = 1'b0;
        time_out_nxt = time_sum;
        note_nxt     = dss_pkg::field7(notes_r, k_r);
        vel_nxt      = '0;
        // last when no higher instrument is still set
        last_nxt     = hit && (((hits >> k_r) >> 1) == '0);
        k_nxt        = k_r + dss_pkg::KIDX_W'(1);
        if (k_r == dss_pkg::KIDX_W'(NI - 1)) state_nxt = dss_pkg::ST_ADVANCE;
      end
      dss_pkg::ST_ADVANCE: begin
        time_op   = bar_r ? dss_pkg::TOP_BAR : dss_pkg::TOP_STEP;
        state_nxt = dss_pkg::ST_IDLE;
      end
      default: state_nxt = dss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= dss_pkg::ST_CLEAR;
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    instr_r    <= instr_nxt;
    is_write_r <= is_write_nxt;
    valid_r    <= valid_nxt;
    odd_r      <= odd_nxt;
    bar_r      <= bar_nxt;
    word_r     <= word_nxt;
    k_r        <= k_nxt;
    note_on_r  <= note_on_nxt;
    time_out_r <= time_out_nxt;
    note_r     <= note_nxt;
    vel_r      <= vel_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swing_r   <= dss_pkg::SWING_RST;
      channel_r <= dss_pkg::CHANNEL_RST;
      notes_r   <= dss_pkg::NOTES_RST;
      vel_nrm_r <= dss_pkg::VEL_NRM_RST;
      vel_acc_r <= dss_pkg::VEL_ACC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dss_pkg::CFG_SWING:   swing_r   <= cfg_data[5:0];
        dss_pkg::CFG_CHANNEL: channel_r <= cfg_data[4:0];
        dss_pkg::CFG_NOTES:   notes_r   <= cfg_data[dss_pkg::TABLE_W-1:0];
        dss_pkg::CFG_VEL_NRM: vel_nrm_r <= cfg_data[dss_pkg::TABLE_W-1:0];
        dss_pkg::CFG_VEL_ACC: vel_acc_r <= cfg_data[dss_pkg::TABLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_strobe       = strobe_r;
  assign out_note_on      = note_on_r;
  assign out_event_time   = time_out_r;
  assign out_channel_out  = channel_r;
  assign out_note_number  = note_r;
  assign out_velocity_out = vel_r;
  assign out_last_event   = last_r;

endmodule

`default_nettype wire

// ----- hdl/dss_checker.sv -----
// Port-level checks for drum_step_sequencer, attached by the bind below.
// Depends on dss_pkg for mode codes.
`timescale 1ns / 1ps
`default_nettype none

module dss_port_checks (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] in_mode,
  input wire logic       out_strobe,
  input wire logic       out_note_on,
  input wire logic [6:0] out_velocity_out,
  input wire logic       out_last_event
);

  // events only appear while a play beat is in progress
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result beat while idle");

  // the read cycle of a play never carries an event
  a_play_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == dss_pkg::MODE_PLAY) |=> (busy && !out_strobe))
    else $error("play beat not followed by read cycle");

  a_off_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_note_on) |-> (out_velocity_out == 7'd0))
    else $error("note-off with nonzero velocity");

  // the last event is a note-off and nothing follows it directly
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_event) |-> !out_note_on ##1 !out_strobe)
    else $error("event after last event of step");

endmodule

bind drum_step_sequencer dss_port_checks u_dss_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_mode          (in_mode),
  .out_strobe       (out_strobe),
  .out_note_on      (out_note_on),
  .out_velocity_out (out_velocity_out),
  .out_last_event   (out_last_event)
);

`default_nettype wire
